// ===== rtl/mvw_pkg.sv =====
// shared constants and types of the moment visibility weight block
package mvw_pkg;

  // fraction bits of the three Q(32-F).F inputs
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned IN_W   = 32;
  localparam int unsigned MAG_W  = IN_W - 1;
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned MSW_W  = MAG_W + FRAC_BITS;
  localparam int unsigned TOL_SH = 21;
  localparam int unsigned TOL_W  = SQ_W - TOL_SH + 6;
  localparam int unsigned DEN_W  = SQ_W + 1;
  localparam int unsigned W_W    = 32;
  localparam int unsigned VIS_W  = 17;

  localparam logic [SQ_W-1:0]  ONE_Q   = SQ_W'(1) << (2 * FRAC_BITS);
  localparam logic [VIS_W-1:0] VIS_ONE = VIS_W'(65536);

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ONE,
    RES_CALC
  } res_e;

  // one restoring division stage
  typedef struct packed {
    res_e             code;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [W_W-1:0]   quo;
  } div_t;

endpackage

// ===== rtl/moment_visibility_weight.sv =====
// moment visibility weight: Chebyshev visibility of a query against stored distance moments
//
// Takes the mean, mean square and query distance (signed Q16.16) and returns the weight in
// unsigned Q1.16, 65536 meaning fully visible. A query is taken every cycle unless the
// output is stalled. The pipe is 38 registers deep: three stages form the squares, the
// tolerance and the special cases, 32 stages each retire one quotient bit of the ratio
// variance/(variance+delta^2) with one 64-bit compare and subtract, two stages cube the
// ratio on 32x32 multipliers, and an output register holds the result. When the output is
// stalled the whole pipe freezes, so nothing is lost or repeated; stall_o follows stall_i
// while a result waits. A negative input or a mean square that is inconsistent with the
// mean gives 0, and a query that does not exceed the mean gives 65536.
module moment_visibility_weight (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic signed [31:0]          dist_mean_i,
  input  logic signed [31:0]          dist_mean_square_i,
  input  logic signed [31:0]          query_distance_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [mvw_pkg::VIS_W-1:0]   visibility_o
);
  import mvw_pkg::*;

  localparam int unsigned NDIV = W_W;

  // global advance: everything moves unless the output holds an untaken result
  logic adv;
  logic out_vld_q;
  assign adv     = !(out_vld_q && stall_i);
  assign stall_o = !adv;

  // ---------------- stage a: magnitudes, mean squared, mean square, query delta
  logic [MAG_W-1:0] m_a, ms_a, d_a;
  logic             neg_a, dgt_a;
  logic [SQ_W-1:0]  m2_a;
  logic [MAG_W-1:0] del_a;
  logic [MSW_W-1:0] msw_a;

  always_comb begin
    m_a   = dist_mean_i[MAG_W-1:0];
    ms_a  = dist_mean_square_i[MAG_W-1:0];
    d_a   = query_distance_i[MAG_W-1:0];
    neg_a = dist_mean_i[IN_W-1] | dist_mean_square_i[IN_W-1] | query_distance_i[IN_W-1];
    dgt_a = d_a > m_a;
    del_a = d_a - m_a;
    m2_a  = SQ_W'(m_a) * SQ_W'(m_a);
    msw_a = {ms_a, {FRAC_BITS{1'b0}}};
  end

  logic             b_vld_q, b_neg_q, b_dgt_q;
  logic [SQ_W-1:0]  b_m2_q;
  logic [MSW_W-1:0] b_msw_q;
  logic [MAG_W-1:0] b_del_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_neg_q <= neg_a;
      b_dgt_q <= dgt_a;
      b_m2_q  <= m2_a;
      b_msw_q <= msw_a;
      b_del_q <= del_a;
    end
  end

  // ---------------- stage b: delta squared, tolerance, variance
  logic [SQ_W-1:0]         del2_b, big_b, msw_ext_b;
  logic [SQ_W-TOL_SH-1:0]  hi_b;
  logic [TOL_SH-1:0]       lo_b;
  logic [TOL_SH+4:0]       lo21_b;
  logic [TOL_W-1:0]        tol_b;
  logic [MSW_W-1:0]        var_b;

  always_comb begin
    del2_b    = SQ_W'(b_del_q) * SQ_W'(b_del_q);
    big_b     = (b_m2_q > ONE_Q) ? b_m2_q : ONE_Q;
    hi_b      = big_b[SQ_W-1:TOL_SH];
    lo_b      = big_b[TOL_SH-1:0];
    // times 21 as 16 + 4 + 1
    lo21_b    = ((TOL_SH+5)'(lo_b) << 4) + ((TOL_SH+5)'(lo_b) << 2) + (TOL_SH+5)'(lo_b);
    tol_b     = (TOL_W'(hi_b) << 4) + (TOL_W'(hi_b) << 2) + TOL_W'(hi_b)
              + TOL_W'(lo21_b[TOL_SH+4:TOL_SH]);
    msw_ext_b = SQ_W'(b_msw_q);
    var_b     = (msw_ext_b > b_m2_q) ? MSW_W'(msw_ext_b - b_m2_q) : '0;
  end

  logic             c_vld_q, c_neg_q, c_dgt_q;
  logic [SQ_W-1:0]  c_m2_q, c_del2_q;
  logic [MSW_W-1:0] c_msw_q, c_var_q;
  logic [TOL_W-1:0] c_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_neg_q  <= b_neg_q;
      c_dgt_q  <= b_dgt_q;
      c_m2_q   <= b_m2_q;
      c_del2_q <= del2_b;
      c_msw_q  <= b_msw_q;
      c_var_q  <= var_b;
      c_tol_q  <= tol_b;
    end
  end

  // ---------------- stage c: consistency check, case selection, divider setup
  logic bad_c;
  div_t div_c;

  always_comb begin
    bad_c = (DEN_W'(c_msw_q) + DEN_W'(c_tol_q)) < DEN_W'(c_m2_q);
    if (c_neg_q || bad_c) begin
      div_c.code = RES_ZERO;
    end else if (!c_dgt_q) begin
      div_c.code = RES_ONE;
    end else begin
      div_c.code = RES_CALC;
    end
    div_c.rem = DEN_W'(c_var_q);
    div_c.den = DEN_W'(c_var_q) + DEN_W'(c_del2_q);
    div_c.quo = '0;
  end

  // ---------------- divider: one quotient bit per stage
  div_t div_q   [NDIV+1];
  logic div_vld_q [NDIV+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q[0] <= 1'b0;
    end else if (adv) begin
      div_vld_q[0] <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= div_c;
    end
  end

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;
    div_t           nxt;

    always_comb begin
      sh       = {div_q[i].rem, 1'b0};
      diff     = sh - {1'b0, div_q[i].den};
      ge       = sh >= {1'b0, div_q[i].den};
      nxt.code = div_q[i].code;
      nxt.den  = div_q[i].den;
      nxt.rem  = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      nxt.quo  = {div_q[i].quo[W_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[i+1] <= 1'b0;
      end else if (adv) begin
        div_vld_q[i+1] <= div_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        div_q[i+1] <= nxt;
      end
    end
  end

  // ---------------- cube: w^2 then w^3
  logic              m1_vld_q;
  res_e              m1_code_q;
  logic [W_W-1:0]    m1_w_q;
  logic [2*W_W-1:0]  m1_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= div_vld_q[NDIV];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_code_q <= div_q[NDIV].code;
      m1_w_q    <= div_q[NDIV].quo;
      m1_p_q    <= (2*W_W)'(div_q[NDIV].quo) * (2*W_W)'(div_q[NDIV].quo);
    end
  end

  logic              m2_vld_q;
  res_e              m2_code_q;
  logic [2*W_W-1:0]  m2_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (adv) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_code_q <= m1_code_q;
      m2_p_q    <= (2*W_W)'(m1_p_q[2*W_W-1:W_W]) * (2*W_W)'(m1_w_q);
    end
  end

  // ---------------- output register
  logic [VIS_W-1:0] vis_d, vis_q;

  always_comb begin
    unique case (m2_code_q)
      RES_CALC: vis_d = VIS_W'(m2_p_q[2*W_W-1:2*W_W-16]);
      RES_ONE:  vis_d = VIS_ONE;
      RES_ZERO: vis_d = '0;
      default:  vis_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= vis_d;
    end
  end

  assign valid_o      = out_vld_q;
  assign visibility_o = vis_q;

  // ---------------- assertions

  // weight never exceeds one
  a_vis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (visibility_o <= VIS_ONE))
    else $error("visibility above one");

  // divider entry: fraction below one whenever a quotient is used
  a_div_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld_q[0] && (div_q[0].code == RES_CALC)) |-> (div_q[0].den > div_q[0].rem))
    else $error("divider numerator not below denominator");

  // negative inputs always resolve to zero weight
  a_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_vld_q && c_neg_q) |-> (div_c.code == RES_ZERO))
    else $error("negative input not forced to zero");

  // a frozen pipe keeps its output
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(vis_q) && $stable(m2_p_q) && $stable(div_q[NDIV].quo)))
    else $error("pipeline moved while stalled");

endmodule

// ===== sim/moment_visibility_weight_tb.sv =====
// self-checking testbench of the moment visibility weight block
module moment_visibility_weight_tb;
  import mvw_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 5;
  // the block's pipe depth, taken from its header, plus some slack for the final drain
  localparam int unsigned PIPE_LATENCY   = 38;
  localparam int unsigned DRAIN_CYCLES   = PIPE_LATENCY + 10;
  // long receiver hold-off, well beyond the pipe depth so the input backs up
  localparam int unsigned HOLD_CYCLES    = 300;
  // cycles without any transfer before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1030;
  localparam int unsigned MAX_REPORTS    = 10;

  // handy Q16.16 values
  localparam logic [31:0] Q_ZERO = 32'h0000_0000;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_TWO  = 32'h0002_0000;
  localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;

  localparam logic [VIS_W-1:0] VIS_NONE = '0;

  // one directed query; pinned rows carry a hand-worked answer, the rest use the predictor
  typedef struct packed {
    logic [31:0]      mean;
    logic [31:0]      msq;
    logic [31:0]      qdist;
    logic             pinned;
    logic [VIS_W-1:0] vis;
  } query_row_t;

  localparam int unsigned DIRECTED_N = 22;
  localparam query_row_t DIRECTED [DIRECTED_N] = '{
    // all zero, query sits on the mean
    '{Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, VIS_ONE},
    // negative inputs, one field at a time, then all of them
    '{Q_MIN, Q_ONE, Q_TWO, 1'b1, VIS_NONE},
    '{Q_ONE, Q_MIN, Q_TWO, 1'b1, VIS_NONE},
    '{Q_ONE, Q_TWO, Q_NEG1, 1'b1, VIS_NONE},
    '{Q_NEG1, Q_NEG1, Q_NEG1, 1'b1, VIS_NONE},
    // largest values: mean squared far above the mean square
    '{Q_MAX, Q_MAX, Q_MAX, 1'b1, VIS_NONE},
    // inconsistent moments win over a query on the mean
    '{Q_TWO, 32'h0003_0000, Q_TWO, 1'b1, VIS_NONE},
    // query equal to the mean
    '{Q_ONE, Q_TWO, Q_ONE, 1'b1, VIS_ONE},
    // zero variance, query beyond the mean
    '{Q_ONE, Q_ONE, Q_TWO, 1'b1, VIS_NONE},
    // mean square short of mean squared, but inside the tolerance
    '{32'h0010_0000, 32'h00FF_FF9C, 32'h0010_0000, 1'b1, VIS_ONE},
    // same, just outside the tolerance
    '{32'h0010_0000, 32'h00FF_FF38, 32'h0010_0000, 1'b1, VIS_NONE},
    // inside the tolerance, so variance clips to zero beyond the mean
    '{32'h0010_0000, 32'h00FF_FF9C, 32'h0020_0000, 1'b1, VIS_NONE},
    // variance equals delta squared: ratio one half, cubed gives 1/8
    '{Q_ONE, Q_TWO, Q_TWO, 1'b1, 17'd8192},
    '{Q_ZERO, Q_ZERO, Q_MAX, 1'b1, VIS_NONE},
    '{Q_ZERO, Q_MAX, Q_MAX, 1'b0, VIS_NONE},
    '{Q_ZERO, Q_MAX, 32'h0000_0001, 1'b0, VIS_NONE},
    '{Q_MAX, Q_ZERO, Q_ZERO, 1'b1, VIS_NONE},
    '{32'h0000_B504, Q_MAX, Q_MAX, 1'b0, VIS_NONE},
    // mean squared right at the top of the mean square range
    '{32'h00B5_04F3, Q_MAX, 32'h00B5_04F4, 1'b0, VIS_NONE},
    '{32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFE, 1'b0, VIS_NONE},
    '{Q_ONE, Q_MAX, Q_MIN, 1'b1, VIS_NONE},
    '{Q_MAX, Q_MAX, Q_MIN, 1'b1, VIS_NONE}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             valid_i;
  logic             stall_o;
  logic [31:0]      dist_mean_i;
  logic [31:0]      dist_mean_square_i;
  logic [31:0]      query_distance_i;
  logic             valid_o;
  logic             stall_i;
  logic [VIS_W-1:0] visibility_o;

  // weights still owed by the block, oldest first
  logic [VIS_W-1:0] vis_expected_q [$];
  logic [VIS_W-1:0] vis_want;
  int unsigned      mismatches  = 0;
  int unsigned      idle_cycles = 0;
  // set by the stimulus, cleared by the receiver once its hold-off is over
  logic             hold_req;

  moment_visibility_weight u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (valid_i),
    .stall_o            (stall_o),
    .dist_mean_i        (dist_mean_i),
    .dist_mean_square_i (dist_mean_square_i),
    .query_distance_i   (query_distance_i),
    .valid_o            (valid_o),
    .stall_i            (stall_i),
    .visibility_o       (visibility_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Chebyshev weight of one query, worked out at full width so no step can overflow
  function automatic logic [VIS_W-1:0] chebyshev_vis(input logic [31:0] mean,
                                                    input logic [31:0] msq,
                                                    input logic [31:0] qdist);
    logic [127:0] m, d, m2, msw, unity, big, tol, variance, dlt, den, w, w2, w3;
    // any negative input means not visible
    if (mean[31] || msq[31] || qdist[31]) return VIS_NONE;
    m     = 128'(mean);
    d     = 128'(qdist);
    m2    = m * m;
    msw   = 128'(msq) << FRAC_BITS;
    unity = 128'(1) << (2 * FRAC_BITS);
    big   = (m2 > unity) ? m2 : unity;
    // tolerance of 21/2^21 of max(m^2, 1.0), truncated
    tol   = (big * 21) >> 21;
    if (msw + tol < m2) return VIS_NONE;
    if (d <= m) return VIS_ONE;
    variance = (msw > m2) ? msw - m2 : '0;
    if (variance == 0) return VIS_NONE;
    dlt = d - m;
    den = variance + dlt * dlt;
    // ratio in Q0.32, then cubed with truncation after each product
    w   = (variance << 32) / den;
    w2  = (w * w) >> 32;
    w3  = (w2 * w) >> 32;
    return VIS_W'(w3 >> 16);
  endfunction

  // sender pause: mostly none, sometimes short, rarely long
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random query: mostly consistent moments with a spread of variances and deltas,
  // some right at the tolerance edge, some raw noise that is often negative
  task automatic make_query(output logic [31:0] m, output logic [31:0] ms,
                            output logic [31:0] d);
    int unsigned kind, mb, vb, db;
    logic [63:0] m2q, slack, acc;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      m  = $urandom;
      ms = $urandom;
      d  = $urandom;
    end else begin
      // mean below 2^23 keeps mean squared inside the mean square range
      mb  = $urandom_range(0, 23);
      m   = $urandom & ((32'd1 << mb) - 32'd1);
      m2q = (64'(m) * 64'(m)) >> FRAC_BITS;
      if (kind < 22) begin
        // short of mean squared by up to twice the tolerance
        slack = $urandom_range(0, 32'(((m2q * 21) >> 21) * 2 + 2));
        acc   = (slack > m2q) ? 64'd0 : m2q - slack;
      end else begin
        vb  = $urandom_range(0, 30);
        acc = m2q + (64'($urandom) & ((64'd1 << vb) - 64'd1));
      end
      if (acc > 64'(Q_MAX)) acc = 64'(Q_MAX);
      ms = acc[31:0];
      if ($urandom_range(0, 3) == 0) begin
        d = m - $urandom_range(0, m);
      end else begin
        db  = $urandom_range(0, 30);
        acc = 64'(m) + (64'($urandom) & ((64'd1 << db) - 64'd1));
        if (acc > 64'(Q_MAX)) acc = 64'(Q_MAX);
        d = acc[31:0];
      end
    end
  endtask

  // offer one query and hold it until the transfer; valid only drops when a gap is taken
  task automatic offer(input logic [31:0] m, input logic [31:0] ms, input logic [31:0] d,
                       input logic [VIS_W-1:0] want, input int unsigned gap);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i            <= 1'b1;
    dist_mean_i        <= m;
    dist_mean_square_i <= ms;
    query_distance_i   <= d;
    do @(posedge clk_i); while (stall_o);
    vis_expected_q = {vis_expected_q, want};
  endtask

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int unsigned r, n;
    logic        v;
    stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          v = 1'b0;
          n = $urandom_range(1, 8);
        end else if (r < 85) begin
          v = 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 94) begin
          v = 1'b1;
          n = $urandom_range(4, 12);
        end else if (r < 97) begin
          v = 1'b1;
          n = $urandom_range(20, 60);
        end else begin
          v = 1'b0;
          n = $urandom_range(50, 150);
        end
        stall_i <= v;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // output check and transfer activity, sampled on the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (vis_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transfer: visibility %0d", visibility_o);
        end else begin
          vis_want = vis_expected_q.pop_front();
          if (visibility_o !== vis_want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("visibility mismatch: expected %0d, got %0d", vis_want, visibility_o);
          end
        end
      end
      if ((valid_i && !stall_o) || (valid_o && !stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // watchdog: too long without any transfer means the block hung
  initial begin
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("** moment_visibility_weight: FAILED **");
    $finish;
  end

  initial begin
    logic [31:0]      m, ms, d;
    logic [VIS_W-1:0] want;
    int unsigned      k;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    valid_i            = 1'b0;
    dist_mean_i        = '0;
    dist_mean_square_i = '0;
    query_distance_i   = '0;
    hold_req           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    for (k = 0; k < DIRECTED_N; k++) begin
      want = DIRECTED[k].pinned ? DIRECTED[k].vis :
             chebyshev_vis(DIRECTED[k].mean, DIRECTED[k].msq, DIRECTED[k].qdist);
      offer(DIRECTED[k].mean, DIRECTED[k].msq, DIRECTED[k].qdist, want, idle_gap());
    end

    // random part opens with the long receiver hold-off while queries keep coming
    hold_req = 1'b1;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      make_query(m, ms, d);
      // every third block of 100 queries runs back to back
      offer(m, ms, d, chebyshev_vis(m, ms, d),
            (hold_req || (k / 100) % 3 == 0) ? 0 : idle_gap());
    end
    valid_i <= 1'b0;

    // wait out the pipe, then a little longer to catch any extra result
    while (vis_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && vis_expected_q.size() == 0) begin
      $display("** moment_visibility_weight: PASSED **");
    end else begin
      $display("** moment_visibility_weight: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mvw_pkg.sv
rtl/moment_visibility_weight.sv
sim/moment_visibility_weight_tb.sv
